@@ hdl/cfa_pkg.sv @@
package cfa_pkg;

  // Default depth of the frame-state store.
  localparam int MAX_FRAMES_DEF = 1024;

  // Field widths.
  localparam int TW  = 2;   // request type
  localparam int FW  = 20;  // absolute frame number
  localparam int PW  = 11;  // frame count, pool size and pool position
  localparam int SW  = 3;   // status code
  localparam int CIW = 1;   // configuration register index

  // Request types.
  localparam logic [TW-1:0] REQ_ALLOC   = 2'd0;
  localparam logic [TW-1:0] REQ_RESERVE = 2'd1;
  localparam logic [TW-1:0] REQ_RELEASE = 2'd2;

  // Per-frame state codes.
  localparam logic [1:0] FS_FREE = 2'b11;
  localparam logic [1:0] FS_HEAD = 2'b01;
  localparam logic [1:0] FS_USED = 2'b00;

  // Status codes.
  localparam logic [SW-1:0] STAT_OK        = 3'd0;
  localparam logic [SW-1:0] STAT_NO_RUN    = 3'd1;
  localparam logic [SW-1:0] STAT_NOT_FREE  = 3'd2;
  localparam logic [SW-1:0] STAT_NOT_HEAD  = 3'd3;
  localparam logic [SW-1:0] STAT_OUT_RANGE = 3'd4;
  localparam logic [SW-1:0] STAT_BAD_COUNT = 3'd5;

  // Configuration register indexes.
  localparam logic [CIW-1:0] REG_POOL_BASE   = 1'b0;
  localparam logic [CIW-1:0] REG_POOL_FRAMES = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_CHECK,
    S_SCAN,
    S_MARK,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [TW-1:0] req_type;
    logic [FW-1:0] frame_number;
    logic [PW-1:0] frame_count;
  } req_t;

  typedef struct packed {
    logic [SW-1:0] status;
    logic [FW-1:0] head_frame;
    logic [PW-1:0] free_frames;
  } result_t;

  // Top level to sequencer.
  typedef struct packed {
    logic req_accept;
    logic init;
    logic res_take;
  } seq_ctl_t;

  // Sequencer to top level.
  typedef struct packed {
    logic busy;
    logic res_valid;
  } seq_status_t;

endpackage

@@ hdl/cfa_ram.sv @@
module cfa_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/cfa_seq.sv @@
module cfa_seq #(
  parameter int MAX_FRAMES = cfa_pkg::MAX_FRAMES_DEF,
  localparam int AW = $clog2(MAX_FRAMES)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfa_pkg::seq_ctl_t     ctl,
  input  cfa_pkg::req_t         req,
  input  logic [cfa_pkg::FW-1:0] pool_base,
  input  logic [cfa_pkg::PW-1:0] pool_size,
  output cfa_pkg::seq_status_t  sts,
  output cfa_pkg::result_t      res,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic [1:0]            mem_wdata,
  output logic [AW-1:0]         mem_raddr,
  input  logic [1:0]            mem_rdata
);

  import cfa_pkg::*;

  seq_state_t    state, state_next;
  logic [TW-1:0] typ, typ_next;
  logic [FW-1:0] fnum, fnum_next;
  logic [PW-1:0] cnt, cnt_next;
  logic [FW-1:0] rel, rel_next;
  logic          under, under_next;
  logic [PW-1:0] pos, pos_next;
  logic [PW-1:0] scan_end, scan_end_next;
  logic          chk_valid, chk_valid_next;
  logic [PW-1:0] chk_pos, chk_pos_next;
  logic [PW-1:0] run, run_next;
  logic [PW-1:0] mark_pos, mark_pos_next;
  logic [PW-1:0] mark_left, mark_left_next;
  logic [PW-1:0] mark_start, mark_start_next;
  logic [PW-1:0] free_cnt, free_cnt_next;
  logic [SW-1:0] stat, stat_next;
  logic          head_ok, head_ok_next;

  logic [FW:0]   rel_diff;
  logic [FW:0]   rsv_end;
  logic          rsv_over;
  logic          rls_out;
  logic [PW-1:0] rel_p;
  logic          last;
  logic [PW-1:0] run_inc;
  logic          found;
  logic          rel_first;
  logic          rls_stop;
  logic          issue;

  assign rel_diff  = {1'b0, fnum} - {1'b0, pool_base};
  assign rsv_end   = {1'b0, rel} + (FW+1)'(cnt);
  assign rsv_over  = rsv_end > (FW+1)'(pool_size);
  assign rls_out   = rel >= FW'(pool_size);
  assign rel_p     = rel[PW-1:0];
  assign last      = (chk_pos + PW'(1)) == scan_end;
  assign run_inc   = (mem_rdata == FS_FREE) ? run + PW'(1) : '0;
  assign found     = run_inc == cnt;
  assign rel_first = chk_pos == rel_p;
  // The head itself must be a head; every frame after it must be a plain used frame.
  assign rls_stop  = rel_first ? (mem_rdata != FS_HEAD) : (mem_rdata != FS_USED);
  assign issue     = (state == S_SCAN) && (pos < scan_end);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (pos >= pool_size) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (ctl.req_accept) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        case (typ)
          REQ_ALLOC: begin
            state_next = (cnt == '0 || cnt > free_cnt) ? S_DONE : S_SCAN;
          end
          REQ_RESERVE: begin
            state_next = (cnt == '0 || under || rsv_over) ? S_DONE : S_SCAN;
          end
          REQ_RELEASE: begin
            state_next = (under || rls_out) ? S_DONE : S_SCAN;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        if (chk_valid) begin
          case (typ)
            REQ_ALLOC: begin
              if (found) begin
                state_next = S_MARK;
              end else if (last) begin
                state_next = S_DONE;
              end
            end
            REQ_RESERVE: begin
              if (mem_rdata != FS_FREE) begin
                state_next = S_DONE;
              end else if (last) begin
                state_next = S_MARK;
              end
            end
            default: begin
              if (rls_stop || last) begin
                state_next = S_DONE;
              end
            end
          endcase
        end
      end
      S_MARK: begin
        if (mark_left == PW'(1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (ctl.res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
    if (ctl.init) begin
      state_next = S_CLEAR;
    end
  end

  // Datapath and store access.
  always_comb begin
    typ_next        = typ;
    fnum_next       = fnum;
    cnt_next        = cnt;
    rel_next        = rel;
    under_next      = under;
    pos_next        = pos;
    scan_end_next   = scan_end;
    chk_valid_next  = issue;
    chk_pos_next    = pos;
    run_next        = run;
    mark_pos_next   = mark_pos;
    mark_left_next  = mark_left;
    mark_start_next = mark_start;
    free_cnt_next   = free_cnt;
    stat_next       = stat;
    head_ok_next    = head_ok;
    mem_we          = 1'b0;
    mem_waddr       = AW'(pos);
    mem_wdata       = FS_FREE;
    mem_raddr       = AW'(pos);

    case (state)
      S_CLEAR: begin
        if (pos < pool_size) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(pos);
          mem_wdata = FS_FREE;
          pos_next  = pos + PW'(1);
        end else begin
          free_cnt_next = pool_size;
        end
      end
      S_IDLE: begin
        if (ctl.req_accept) begin
          typ_next     = req.req_type;
          fnum_next    = req.frame_number;
          cnt_next     = req.frame_count;
          stat_next    = STAT_OK;
          head_ok_next = 1'b0;
        end
      end
      S_PREP: begin
        rel_next   = rel_diff[FW-1:0];
        under_next = rel_diff[FW];
      end
      S_CHECK: begin
        run_next = '0;
        case (typ)
          REQ_ALLOC: begin
            if (cnt == '0) begin
              stat_next = STAT_BAD_COUNT;
            end else if (cnt > free_cnt) begin
              stat_next = STAT_NO_RUN;
            end else begin
              pos_next      = '0;
              scan_end_next = pool_size;
            end
          end
          REQ_RESERVE: begin
            if (cnt != '0) begin
              if (under || rsv_over) begin
                stat_next = STAT_OUT_RANGE;
              end else begin
                pos_next      = rel_p;
                scan_end_next = rel_p + cnt;
              end
            end
          end
          REQ_RELEASE: begin
            if (under || rls_out) begin
              stat_next = STAT_OUT_RANGE;
            end else begin
              pos_next      = rel_p;
              scan_end_next = pool_size;
            end
          end
          default: begin
            stat_next = STAT_OK;
          end
        endcase
      end
      S_SCAN: begin
        // Reads run one frame ahead of the check of the word that comes back.
        if (issue) begin
          pos_next = pos + PW'(1);
        end
        if (chk_valid) begin
          case (typ)
            REQ_ALLOC: begin
              run_next = run_inc;
              if (found) begin
                mark_start_next = chk_pos + PW'(1) - cnt;
                mark_pos_next   = chk_pos + PW'(1) - cnt;
                mark_left_next  = cnt;
                head_ok_next    = 1'b1;
              end else if (last) begin
                stat_next = STAT_NO_RUN;
              end
            end
            REQ_RESERVE: begin
              if (mem_rdata != FS_FREE) begin
                stat_next = STAT_NOT_FREE;
              end else if (last) begin
                mark_start_next = rel_p;
                mark_pos_next   = rel_p;
                mark_left_next  = cnt;
              end
            end
            default: begin
              if (rls_stop) begin
                if (rel_first) begin
                  stat_next = STAT_NOT_HEAD;
                end
              end else begin
                mem_we        = 1'b1;
                mem_waddr     = AW'(chk_pos);
                mem_wdata     = FS_FREE;
                free_cnt_next = free_cnt + PW'(1);
              end
            end
          endcase
        end
      end
      S_MARK: begin
        mem_we         = 1'b1;
        mem_waddr      = AW'(mark_pos);
        mem_wdata      = (mark_pos == mark_start) ? FS_HEAD : FS_USED;
        mark_pos_next  = mark_pos + PW'(1);
        mark_left_next = mark_left - PW'(1);
        if (mark_left == PW'(1)) begin
          free_cnt_next = free_cnt - cnt;
        end
      end
      S_DONE: begin
        stat_next = stat;
      end
      default: begin
        pos_next = '0;
      end
    endcase

    if (ctl.init) begin
      pos_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      pos       <= '0;
      chk_valid <= 1'b0;
      free_cnt  <= '0;
      head_ok   <= 1'b0;
    end else begin
      state     <= state_next;
      pos       <= pos_next;
      chk_valid <= chk_valid_next;
      free_cnt  <= free_cnt_next;
      head_ok   <= head_ok_next;
    end
    typ        <= typ_next;
    fnum       <= fnum_next;
    cnt        <= cnt_next;
    rel        <= rel_next;
    under      <= under_next;
    scan_end   <= scan_end_next;
    chk_pos    <= chk_pos_next;
    run        <= run_next;
    mark_pos   <= mark_pos_next;
    mark_left  <= mark_left_next;
    mark_start <= mark_start_next;
    stat       <= stat_next;
  end

  assign sts.busy        = state != S_IDLE;
  assign sts.res_valid   = state == S_DONE;
  assign res.status      = stat;
  assign res.head_frame  = head_ok ? pool_base + FW'(mark_start) : '0;
  assign res.free_frames = free_cnt;

endmodule

@@ hdl/contiguous_frame_allocator_core.sv @@
// Contiguous frame allocator. A pool of up to MAX_FRAMES frames, starting at
// pool_base, is tracked with a 2-bit state per frame in a frame-state RAM
// that is read and written through one sequencer, one frame per cycle. After
// reset and after each configuration write the RAM is swept to all-free, and
// no request word is taken meanwhile. A request then passes range and count
// checks in the PREP and CHECK states; one that the checks settle goes
// straight to its result. Any other first fills the RAM read pipeline and
// then: for allocate, scans from frame 0 up to the end of the first fitting
// run (the whole pool when none fits) and marks the run; for reserve, checks
// frames up to frame_count or the first frame that is not free, and marks a
// free run; for release, frees each frame of the run and reads the frame that
// ends the run, unless the run reaches the end of the pool. The DONE state then
// hands the result word to the output register, which holds it while the next
// request runs; DONE lasts while the register still holds a stalled word. The
// block then returns to IDLE, where it takes the next request word.
module contiguous_frame_allocator_core #(
  parameter int MAX_FRAMES = cfa_pkg::MAX_FRAMES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  logic [cfa_pkg::TW-1:0]  req_type,
  input  logic [cfa_pkg::FW-1:0]  frame_number,
  input  logic [cfa_pkg::PW-1:0]  frame_count,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output logic [cfa_pkg::SW-1:0]  status,
  output logic [cfa_pkg::FW-1:0]  head_frame,
  output logic [cfa_pkg::PW-1:0]  free_frames,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [cfa_pkg::CIW-1:0] cfg_index,
  input  logic [cfa_pkg::FW-1:0]  cfg_data
);

  import cfa_pkg::*;

  localparam int AW = $clog2(MAX_FRAMES);
  localparam logic [PW-1:0] MAX_CAP =
      (MAX_FRAMES > (2**PW - 1)) ? {PW{1'b1}} : PW'(MAX_FRAMES);

  logic [FW-1:0] pool_base;
  logic [PW-1:0] pool_frames;
  logic [PW-1:0] pool_size;
  seq_ctl_t      ctl;
  seq_status_t   sts;
  req_t          req;
  result_t       res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [1:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [1:0]    mem_rdata;

  assign cfg_ready = 1'b1;
  assign pool_size = (pool_frames > MAX_CAP) ? MAX_CAP : pool_frames;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base   <= '0;
      pool_frames <= PW'(1024);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POOL_BASE: begin
          pool_base <= cfg_data;
        end
        REG_POOL_FRAMES: begin
          pool_frames <= cfg_data[PW-1:0];
        end
        default: begin
          pool_base <= pool_base;
        end
      endcase
    end
  end

  assign req_stall        = sts.busy;
  assign req.req_type     = req_type;
  assign req.frame_number = frame_number;
  assign req.frame_count  = frame_count;

  assign ctl.req_accept = req_valid && !req_stall;
  assign ctl.init       = cfg_valid && cfg_ready;
  assign ctl.res_take   = !rsp_valid || !rsp_stall;

  cfa_seq #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .req      (req),
    .pool_base(pool_base),
    .pool_size(pool_size),
    .sts      (sts),
    .res      (res),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  cfa_ram #(
    .WIDTH(2),
    .DEPTH(MAX_FRAMES)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Output register: the finished word waits here while the next request runs.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.res_take) begin
      rsp_valid <= sts.res_valid;
    end
    if (ctl.res_take && sts.res_valid) begin
      status      <= res.status;
      head_frame  <= res.head_frame;
      free_frames <= res.free_frames;
    end
  end

  // Once a request is taken the block stays busy for at least the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken but block not busy afterwards");

  // A head frame is only reported for a successful allocate.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && head_frame != '0 |-> status == STAT_OK)
    else $error("head frame reported with an error status");

  // A new result word only appears when the sequencer has one ready.
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(sts.res_valid))
    else $error("result word appeared without a finished request");

endmodule

@@ tb/sv/contiguous_frame_allocator_core_tb.sv @@
`timescale 1ns / 1ps

module contiguous_frame_allocator_core_tb;
  import cfa_pkg::*;

  localparam int DEPTH = MAX_FRAMES_DEF;
  // Request type that the block ignores.
  localparam logic [TW-1:0] REQ_UNKNOWN = 2'd3;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  logic [TW-1:0] req_type = '0;
  logic [FW-1:0] frame_number = '0;
  logic [PW-1:0] frame_count = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  logic [SW-1:0] status;
  logic [FW-1:0] head_frame;
  logic [PW-1:0] free_frames;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [CIW-1:0] cfg_index = '0;
  logic [FW-1:0]  cfg_data = '0;

  contiguous_frame_allocator_core dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_type(req_type),
    .frame_number(frame_number),
    .frame_count(frame_count),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .status(status),
    .head_frame(head_frame),
    .free_frames(free_frames),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow of the allocator: per-frame state, free count and pool settings.
  logic [1:0]    shadow_state [0:DEPTH-1];
  int            free_count;
  int            pool_n;
  logic [FW-1:0] base_frame;
  logic [PW-1:0] pool_setting;

  req_t    pending_requests [$];
  result_t expected_results [$];
  int      mismatch_count = 0;

  function automatic void reset_pool();
    int i;
    for (i = 0; i < DEPTH; i++) shadow_state[i] = FS_FREE;
    pool_n = (int'(pool_setting) > DEPTH) ? DEPTH : int'(pool_setting);
    free_count = pool_n;
  endfunction

  function automatic void claim_run(input int first, input int count);
    int i;
    for (i = 0; i < count; i++) shadow_state[first + i] = (i == 0) ? FS_HEAD : FS_USED;
    free_count -= count;
  endfunction

  function automatic logic [FW-1:0] abs_frame(input int rel);
    return base_frame + rel[FW-1:0];
  endfunction

  // Applies one request to the shadow state and queues the result word it gives.
  function automatic void predict_result(input logic [TW-1:0] kind, input logic [FW-1:0] fnum,
                                         input logic [PW-1:0] cnt);
    result_t r;
    int      fn_i;
    int      base_i;
    int      cnt_i;
    int      run;
    int      rel;
    int      i;
    bit      done;
    r = '0;
    r.status = STAT_OK;
    fn_i = int'(fnum);
    base_i = int'(base_frame);
    cnt_i = int'(cnt);
    done = 1'b0;
    case (kind)
      REQ_ALLOC: begin
        if (cnt_i == 0) begin
          r.status = STAT_BAD_COUNT;
        end else begin
          r.status = STAT_NO_RUN;
          if (cnt_i <= free_count) begin
            run = 0;
            for (i = 0; i < pool_n && !done; i++) begin
              if (shadow_state[i] == FS_FREE) run++;
              else run = 0;
              if (run == cnt_i) begin
                claim_run(i + 1 - cnt_i, cnt_i);
                r.head_frame = abs_frame(i + 1 - cnt_i);
                r.status = STAT_OK;
                done = 1'b1;
              end
            end
          end
        end
      end
      REQ_RESERVE: begin
        if (cnt_i != 0) begin
          if (fn_i < base_i || (fn_i - base_i) + cnt_i > pool_n) begin
            r.status = STAT_OUT_RANGE;
          end else begin
            rel = fn_i - base_i;
            for (i = 0; i < cnt_i; i++)
              if (shadow_state[rel + i] != FS_FREE) r.status = STAT_NOT_FREE;
            if (r.status == STAT_OK) claim_run(rel, cnt_i);
          end
        end
      end
      REQ_RELEASE: begin
        if (fn_i < base_i || fn_i - base_i >= pool_n) begin
          r.status = STAT_OUT_RANGE;
        end else begin
          rel = fn_i - base_i;
          if (shadow_state[rel] != FS_HEAD) begin
            r.status = STAT_NOT_HEAD;
          end else begin
            shadow_state[rel] = FS_FREE;
            free_count++;
            // Trailing frames go back until a free frame or another head.
            for (i = rel + 1; i < pool_n && !done; i++) begin
              if (shadow_state[i] != FS_USED) begin
                done = 1'b1;
              end else begin
                shadow_state[i] = FS_FREE;
                free_count++;
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.free_frames = free_count[PW-1:0];
    expected_results.push_back(r);
  endfunction

  // Builds a request from the current shadow state, mostly well formed.
  function automatic req_t next_request();
    req_t r;
    int   pick;
    int   rel;
    int   span;
    int   small_max;
    int   heads [$];
    int   k;
    int   tries;
    bit   clear;
    r.req_type = REQ_ALLOC;
    r.frame_number = FW'($urandom_range(0, 20'hFFFFF));
    r.frame_count = PW'($urandom_range(0, 2047));
    small_max = (pool_n / 4 > 8) ? 8 : ((pool_n / 4 < 1) ? 1 : pool_n / 4);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      r.req_type = REQ_ALLOC;
      if (pick < 4) r.frame_count = '0;
      else if (pick < 12 && free_count > 0) r.frame_count = PW'($urandom_range(1, free_count));
      else if (pick >= 12) r.frame_count = PW'($urandom_range(1, small_max));
    end else if (pick < 70) begin
      r.req_type = REQ_RELEASE;
      for (k = 0; k < pool_n; k++) if (shadow_state[k] == FS_HEAD) heads.push_back(k);
      if (pick < 62 && heads.size() > 0) rel = heads[$urandom_range(0, heads.size() - 1)];
      else if (pick < 66 && pool_n > 0) rel = $urandom_range(0, pool_n - 1);
      else if ($urandom_range(0, 1) == 1) rel = pool_n + int'($urandom_range(0, 3));
      else rel = -1 - int'($urandom_range(0, 3));
      r.frame_number = abs_frame(rel);
    end else if (pick < 90) begin
      r.req_type = REQ_RESERVE;
      span = $urandom_range(1, small_max);
      rel = 0;
      if (pick < 84) begin
        clear = 1'b0;
        for (tries = 0; tries < 8 && !clear && pool_n >= span; tries++) begin
          rel = $urandom_range(0, pool_n - span);
          clear = 1'b1;
          for (k = 0; k < span; k++) if (shadow_state[rel + k] != FS_FREE) clear = 1'b0;
        end
      end else if (pick < 86) begin
        span = 0;
        if (pool_n > 0) rel = $urandom_range(0, pool_n - 1);
      end else if (pick < 88) begin
        if ($urandom_range(0, 1) == 1) rel = pool_n - span + 1 + int'($urandom_range(0, 2));
        else rel = -1 - int'($urandom_range(0, 3));
      end else if (pool_n > 0) begin
        rel = $urandom_range(0, pool_n - 1);
      end
      r.frame_number = abs_frame(rel);
      r.frame_count = PW'(span);
    end else if (pick < 95) begin
      r.req_type = REQ_UNKNOWN;
    end else begin
      r.req_type = TW'($urandom_range(0, 3));
    end
    return r;
  endfunction

  // Sender: bursts of words with random gaps; predicts each word it gets accepted.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : drive_requests
    req_t item;
    logic taken;
    if (rst) begin
      req_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      taken = req_valid && !req_stall;
      if (taken) predict_result(req_type, frame_number, frame_count);
      if (!req_valid || taken) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          req_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          item = pending_requests.pop_front();
          req_type <= item.req_type;
          frame_number <= item.frame_number;
          frame_count <= item.frame_count;
          req_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 10);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern switches between none, scattered and long runs.
  int stall_mode = 0;
  int mode_timer = 0;

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_mode <= 0;
      mode_timer <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word: status %0d head %05h free %0d", $time,
                   status, head_frame, free_frames);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            mismatch_count++;
          end
          if (head_frame !== want.head_frame) begin
            $display("%0t: head_frame expected %05h actual %05h", $time, want.head_frame,
                     head_frame);
            mismatch_count++;
          end
          if (free_frames !== want.free_frames) begin
            $display("%0t: free_frames expected %0d actual %0d", $time, want.free_frames,
                     free_frames);
            mismatch_count++;
          end
        end
      end
      if (mode_timer == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_timer <= $urandom_range(50, 400);
      end else begin
        mode_timer <= mode_timer - 1;
      end
      case (stall_mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 3) == 0);
        default: rsp_stall <= ((mode_timer % 32) < 20);
      endcase
    end
  end

  task automatic queue_request(input logic [TW-1:0] kind, input logic [FW-1:0] fnum,
                               input logic [PW-1:0] cnt);
    req_t r;
    r.req_type = kind;
    r.frame_number = fnum;
    r.frame_count = cnt;
    pending_requests.push_back(r);
  endtask

  task automatic drain_requests();
    @(negedge clk);
    while (pending_requests.size() != 0 || req_valid) @(negedge clk);
  endtask

  task automatic wait_results();
    drain_requests();
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CIW-1:0] idx, input logic [FW-1:0] value);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_POOL_BASE) base_frame = value;
    else pool_setting = value[PW-1:0];
    reset_pool();
  endtask

  // Each new request is built only once the previous one has been taken, so the
  // shadow state it is drawn from is exact.
  task automatic random_requests(input int count);
    repeat (count) begin
      drain_requests();
      if ($urandom_range(0, 49) == 0) wait_results();
      pending_requests.push_back(next_request());
    end
  endtask

  task automatic run_phase(input logic [FW-1:0] base, input logic [FW-1:0] frames,
                           input int count);
    wait_results();
    repeat (4) @(posedge clk);
    write_reg(REG_POOL_BASE, base);
    write_reg(REG_POOL_FRAMES, frames);
    random_requests(count);
  endtask

  initial begin
    base_frame = '0;
    pool_setting = PW'(DEPTH);
    reset_pool();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    queue_request(REQ_ALLOC, 20'h0, 11'd0);
    queue_request(REQ_ALLOC, 20'h0, 11'd2047);
    queue_request(REQ_ALLOC, 20'hFFFFF, 11'd1);
    queue_request(REQ_ALLOC, 20'h0, 11'd3);
    queue_request(REQ_RESERVE, 20'd10, 11'd4);
    queue_request(REQ_RESERVE, 20'd11, 11'd2);
    queue_request(REQ_RESERVE, 20'd0, 11'd0);
    queue_request(REQ_RESERVE, 20'd1020, 11'd5);
    queue_request(REQ_RESERVE, 20'd1020, 11'd4);
    queue_request(REQ_RELEASE, 20'd1020, 11'd0);
    queue_request(REQ_RELEASE, 20'd2, 11'd0);
    queue_request(REQ_RELEASE, 20'd500, 11'd0);
    queue_request(REQ_RELEASE, 20'd1024, 11'd0);
    queue_request(REQ_RELEASE, 20'hFFFFF, 11'd2047);
    queue_request(REQ_RELEASE, 20'd1, 11'd0);
    queue_request(REQ_UNKNOWN, 20'hFFFFF, 11'd2047);
    queue_request(REQ_ALLOC, 20'd0, 11'd1019);
    queue_request(REQ_ALLOC, 20'd0, 11'd1010);
    queue_request(REQ_ALLOC, 20'd0, 11'd1);
    queue_request(REQ_RELEASE, 20'd14, 11'd0);
    random_requests(30);

    run_phase(20'h12345, 20'd16, 90);
    // Allocated heads wrap past the top of the frame number space.
    run_phase(20'hFFFF8, 20'd16, 60);
    run_phase(20'h00000, 20'd1, 30);
    run_phase(20'hABCDE, 20'd0, 10);
    run_phase(20'h00000, 20'd2047, 25);
    run_phase(FW'($urandom_range(0, 20'hFFFFF)), 20'd64, 120);
    run_phase(20'hFFFFF, 20'd8, 60);
    run_phase(FW'($urandom_range(0, 20'hFFFFF)), 20'd32, 150);

    wait_results();
    repeat (2200) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("contiguous_frame_allocator_core_tb: PASS");
    end else begin
      $display("contiguous_frame_allocator_core_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #(100_000_000);
    $display("contiguous_frame_allocator_core_tb: FAIL");
    $finish;
  end

endmodule
